// ----- sv/rau_pkg.sv -----
package rau_pkg;

  // Operand and result widths
  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int NUM_W         = 2 * OPERAND_WIDTH + 1;
  localparam int DEN_W         = 2 * OPERAND_WIDTH - 1;
  localparam int MAG_W         = 2 * OPERAND_WIDTH;
  localparam int CNT_W         = $clog2(MAG_W);

  // Stream payload widths, rounded up to whole bytes
  localparam int IN_BITS       = 2 + 4 * OPERAND_WIDTH;
  localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS      = NUM_W + DEN_W;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  // Queue between front and back (depth is a power of two)
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);

  // Operation codes
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DIV = 2'd3;

  // Classified request handed from front to back
  typedef struct packed {
    logic             dz;
    logic             neg;
    logic [MAG_W-1:0] un;
    logic [DEN_W-1:0] ud;
  } rau_item_t;

endpackage

// ----- sv/rau_front.sv -----
module rau_front
  import rau_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [1:0]                      func,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic signed [OPERAND_WIDTH-1:0] a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic signed [OPERAND_WIDTH-1:0] b_den,
  output logic                            item_valid,
  input  logic                            item_ready,
  output rau_item_t                       item
);

  localparam logic [2:0] F_IDLE    = 3'd0;
  localparam logic [2:0] F_MUL_DEN = 3'd1;
  localparam logic [2:0] F_MUL_P1  = 3'd2;
  localparam logic [2:0] F_MUL_P2  = 3'd3;
  localparam logic [2:0] F_PUSH    = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [1:0]                      func_r;
  logic signed [OPERAND_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [PROD_W-1:0]        den_r, p1_r, p2_r;
  logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]        prod;
  logic signed [NUM_W-1:0]         p1_ext, p2_ext, num_s, num_neg;
  logic signed [PROD_W-1:0]        den_neg;

  assign req_ready  = (state_r == F_IDLE);
  assign item_valid = (state_r == F_PUSH);

  // Select operands of the shared multiplier by step
  always_comb begin
    mul_a = ad_r;
    mul_b = bd_r;
    unique case (state_r)
      F_MUL_DEN: begin
        mul_a = ad_r;
        mul_b = (func_r == FUNC_DIV) ? bn_r : bd_r;
      end
      F_MUL_P1: begin
        mul_a = an_r;
        mul_b = (func_r == FUNC_MUL) ? bn_r : bd_r;
      end
      F_MUL_P2: begin
        mul_a = ad_r;
        mul_b = bn_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Form raw numerator, then magnitudes and sign
  assign p1_ext  = {p1_r[PROD_W-1], p1_r};
  assign p2_ext  = {p2_r[PROD_W-1], p2_r};
  assign den_neg = -den_r;

  always_comb begin
    case (func_r)
      FUNC_ADD: num_s = p1_ext + p2_ext;
      FUNC_SUB: num_s = p1_ext - p2_ext;
      default:  num_s = p1_ext;
    endcase
  end

  assign num_neg = -num_s;

  always_comb begin
    item.dz  = (den_r == '0);
    item.neg = num_s[NUM_W-1] ^ den_r[PROD_W-1];
    item.un  = num_s[NUM_W-1] ? num_neg[MAG_W-1:0] : num_s[MAG_W-1:0];
    item.ud  = den_r[PROD_W-1] ? den_neg[DEN_W-1:0] : den_r[DEN_W-1:0];
  end

  // Step sequence
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:    if (req_valid) state_nxt = F_MUL_DEN;
      F_MUL_DEN: state_nxt = F_MUL_P1;
      F_MUL_P1:  state_nxt = F_MUL_P2;
      F_MUL_P2:  state_nxt = F_PUSH;
      F_PUSH:    if (item_ready) state_nxt = F_IDLE;
      default:   state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture operands and products
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && req_valid) begin
      func_r <= func;
      an_r   <= a_num;
      ad_r   <= a_den;
      bn_r   <= b_num;
      bd_r   <= b_den;
    end
    if (state_r == F_MUL_DEN) den_r <= prod;
    if (state_r == F_MUL_P1)  p1_r  <= prod;
    if (state_r == F_MUL_P2)  p2_r  <= prod;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH && !item_ready) |=> (state_r == F_PUSH))
    else $error("front left push step without hand-off");

endmodule

// ----- sv/rau_queue.sv -----
module rau_queue
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  rau_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output rau_item_t pop_item
);

  rau_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W + 1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W + 1)'(QDEPTH))
    else $error("queue fill count above depth");

endmodule

// ----- sv/rau_back.sv -----
module rau_back
  import rau_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  rau_item_t        item,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [NUM_W-1:0] res_num,
  output logic [DEN_W-1:0] res_den,
  output logic             div_zero
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_GCD  = 2'd1;
  localparam logic [1:0] B_DIV  = 2'd2;
  localparam logic [1:0] B_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic             dz_r, neg_r;
  logic [MAG_W-1:0] un_r, ud_r;
  logic [MAG_W-1:0] x_r, y_r, g_r;
  logic [CNT_W-1:0] k_r, cnt_r;
  logic [MAG_W:0]   rn_r, rd_r;
  logic [MAG_W:0]   rn_sh, rd_sh, g_ext;
  logic             n_bit, d_bit;
  logic [MAG_W-1:0] diff_xy, diff_yx;
  logic             out_valid_r;
  logic [NUM_W-1:0] out_num_r;
  logic [DEN_W-1:0] out_den_r;
  logic             out_dz_r;
  logic             load_out;
  logic [NUM_W-1:0] num_pos;

  assign item_ready = (state_r == B_IDLE);
  assign load_out   = (state_r == B_DONE) && (!out_valid_r || res_ready);
  assign res_valid  = out_valid_r;
  assign res_num    = out_num_r;
  assign res_den    = out_den_r;
  assign div_zero   = out_dz_r;

  // One binary GCD step
  assign diff_xy = x_r - y_r;
  assign diff_yx = y_r - x_r;

  // One restoring division step for both quotients, shared divisor
  assign g_ext = {1'b0, g_r};
  assign rn_sh = {rn_r[MAG_W-1:0], x_r[MAG_W-1]};
  assign rd_sh = {rd_r[MAG_W-1:0], y_r[MAG_W-1]};
  assign n_bit = (rn_sh >= g_ext);
  assign d_bit = (rd_sh >= g_ext);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (item_valid) state_nxt = item.dz ? B_DONE : B_GCD;
      B_GCD:  if (x_r == '0) state_nxt = B_DIV;
      B_DIV:  if (cnt_r == CNT_W'(MAG_W - 1)) state_nxt = B_DONE;
      B_DONE: if (load_out) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: take request, reduce, divide out the GCD
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (item_valid) begin
          dz_r  <= item.dz;
          neg_r <= item.neg;
          un_r  <= item.un;
          ud_r  <= {1'b0, item.ud};
          x_r   <= item.un;
          y_r   <= {1'b0, item.ud};
          k_r   <= '0;
        end
      end
      B_GCD: begin
        if (x_r == '0) begin
          g_r   <= y_r << k_r;
          x_r   <= un_r;
          y_r   <= ud_r;
          rn_r  <= '0;
          rd_r  <= '0;
          cnt_r <= '0;
        end else if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= diff_xy >> 1;
        end else begin
          y_r <= diff_yx >> 1;
        end
      end
      B_DIV: begin
        rn_r  <= n_bit ? (rn_sh - g_ext) : rn_sh;
        rd_r  <= d_bit ? (rd_sh - g_ext) : rd_sh;
        x_r   <= {x_r[MAG_W-2:0], n_bit};
        y_r   <= {y_r[MAG_W-2:0], d_bit};
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register: sign onto numerator, zeros on error
  assign num_pos = {1'b0, x_r};

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_dz_r <= dz_r;
      if (dz_r) begin
        out_num_r <= '0;
        out_den_r <= '0;
      end else begin
        out_num_r <= (neg_r && x_r != '0) ? -num_pos : num_pos;
        out_den_r <= y_r[DEN_W-1:0];
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_GCD) |-> (y_r != '0))
    else $error("GCD operand reached zero");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (g_r != '0))
    else $error("zero divisor in reduction");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_dz_r) |-> (out_den_r != '0))
    else $error("zero denominator without error flag");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dz_r) |-> (out_den_r == '0 && out_num_r == '0))
    else $error("error result carries nonzero value");

endmodule

// ----- sv/rational_arithmetic_unit_core.sv -----
// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// fractions and returns the result in lowest terms with a positive denominator.
// Input stream in_*: one request per accepted item (tvalid && tready), tdata
// carries func, a_num, a_den, b_num, b_den. Output stream out_*: one result
// per request, in order; tdata carries res_num and res_den, tuser div_zero.
// A zero raw denominator gives div_zero = 1 with zero numerator/denominator.
// Steps: the front end forms three products through one shared 16x16
// multiplier, then sign and magnitude; the back end takes the request, runs
// binary GCD steps (one step per cycle, bounded by the total magnitude bits),
// then restoring division by the GCD (one quotient bit per cycle for numerator
// and denominator together), then loads the output register. A zero raw
// denominator skips the reduction and goes straight to the output register.
// The back end takes a new request only once the last one has left for the
// output register; the front end can take the next one while the queue has room.
// A two-entry queue decouples the front end from the back end, and the output
// register lets the back end start the next request while a result waits.
// in_tready is high only while the front end is idle: it drops after each request
// while the front end forms its products, and stays low while it waits on a full queue.
// Reset (rst_n low, synchronous) empties the queue, drops out_tvalid and idles all.
module rational_arithmetic_unit_core
  import rau_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] func, [17:2] a_num, [33:18] a_den, [49:34] b_num, [65:50] b_den
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [32:0] res_num, [63:33] res_den
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] div_zero
  output logic                   out_tuser
);

  localparam int W = OPERAND_WIDTH;

  rau_item_t        f_item, q_item;
  logic             f_valid, f_ready, q_valid, q_ready;
  logic [NUM_W-1:0] res_num;
  logic [DEN_W-1:0] res_den;

  // Classify and cross-multiply
  rau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .func       (in_tdata[1:0]),
    .a_num      (in_tdata[2 + W - 1 : 2]),
    .a_den      (in_tdata[2 + 2*W - 1 : 2 + W]),
    .b_num      (in_tdata[2 + 3*W - 1 : 2 + 2*W]),
    .b_den      (in_tdata[2 + 4*W - 1 : 2 + 3*W]),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  // Hold requests between the two halves
  rau_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Reduce to lowest terms
  rau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_num    (res_num),
    .res_den    (res_den),
    .div_zero   (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'({res_den, res_num});

endmodule
